// ----- rtl/core/bpss_pkg.sv -----
// ----------------------------------------------------------------------------
// bpss_pkg
// Shared types and constants for the binary patch size scanner.
// ----------------------------------------------------------------------------
package bpss_pkg;

    // Header layout: three big-endian 32-bit words (start, end, data length)
    localparam logic [3:0] HEADER_BYTES = 4'd12;
    localparam logic [3:0] WORD_BYTES   = 4'd4;
    localparam int         PAIR_BYTES   = 8;
    localparam int         PAIR_W       = PAIR_BYTES * 8;

    // Width of one size contribution: a hunk term (start - prev_end + len)
    // plus the closing term (orig_length - end) always fits in 35 signed bits.
    localparam int DELTA_W = 35;
    localparam int SIZE_W  = 64;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Command from front to back
    typedef struct packed {
        logic                      finish;  // close the stream, emit a result
        logic                      bad;     // stream cannot be decoded
        logic signed [DELTA_W-1:0] delta;   // amount to add to the running size
    } cmd_t;

endpackage

// ----- rtl/core/binary_patch_size_scanner.sv -----
// ----------------------------------------------------------------------------
// binary_patch_size_scanner
// Computes the length of the text that a binary delta produces.
// ----------------------------------------------------------------------------
// The block takes one delta byte per request on the patch channel and accepts
// a new request every cycle while the command queue has room; the rate is one
// byte per clock, set by the front end's byte-wide header and skip logic.
// Each hunk is a 12-byte header of big-endian start, end and length words
// followed by length data bytes that are skipped. The request with last_item
// high closes the stream and yields one result request: patched_size = sum of
// (start - previous end + length) over all hunks, plus orig_length - final
// end, wrapping at 64 bits, with status 0. A header whose start exceeds its
// end, or a stream that stops inside a header or inside hunk data, gives
// status 1 and size 0. A request with byte_valid low carries no byte; with
// last_item high it ends the stream, so an empty delta reports orig_length.
// The result of a stream passes from the last request through the queue and
// then through the output register, and it waits in that register while
// the next stream's bytes keep flowing. patch_ready drops only when the next
// stream's closing request and one more command fill the two-entry queue
// behind a waiting result; it rises again at the edge where that result is
// taken. Write orig_length through cfg_wr_en / cfg_wr_data only while the
// block is idle; it survives across streams and resets to zero.
// ----------------------------------------------------------------------------
module binary_patch_size_scanner (
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration
    input  logic                         cfg_wr_en,
    input  logic [31:0]                  cfg_wr_data,
    // delta byte requests
    input  logic                         patch_valid,
    output logic                         patch_ready,
    input  logic [7:0]                   patch_byte,
    input  logic                         byte_valid,
    input  logic                         last_item,
    // result requests
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [bpss_pkg::SIZE_W-1:0]  patched_size,
    output logic                         status
);
    import bpss_pkg::*;

    logic [31:0] orig_length_reg;
    cmd_t        front_cmd;
    cmd_t        queue_head;
    logic        front_push;
    logic        queue_pop;
    logic        queue_not_empty;
    logic        queue_full;

    // Hold the original length; the user must write it only while idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orig_length_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            orig_length_reg <= cfg_wr_data;
        end
    end

    // Front end: assemble headers, skip data, classify each byte, and issue a
    // size request when a hunk completes or the stream ends.
    bpss_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .patch_valid (patch_valid),
        .patch_ready (patch_ready),
        .patch_byte  (patch_byte),
        .byte_valid  (byte_valid),
        .last_item   (last_item),
        .orig_length (orig_length_reg),
        .queue_full  (queue_full),
        .push        (front_push),
        .cmd         (front_cmd)
    );

    // Queue: decouple byte intake from result backpressure.
    bpss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_push),
        .push_data (front_cmd),
        .pop       (queue_pop),
        .head      (queue_head),
        .not_empty (queue_not_empty),
        .full      (queue_full)
    );

    // Back end: advance the 64-bit running size and present the result.
    bpss_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (queue_head),
        .not_empty    (queue_not_empty),
        .pop          (queue_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .patched_size (patched_size),
        .status       (status)
    );

    a_stall_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !patch_ready |-> queue_full)
        else $error("byte requests stalled without a full queue");

endmodule

// ----- rtl/core/bpss_front.sv -----
// ----------------------------------------------------------------------------
// bpss_front
// Accepts delta bytes, assembles hunk headers, skips hunk data and issues
// size commands to the back end.
// ----------------------------------------------------------------------------
module bpss_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  patch_valid,
    output logic                  patch_ready,
    input  logic [7:0]            patch_byte,
    input  logic                  byte_valid,
    input  logic                  last_item,
    input  logic [31:0]           orig_length,
    input  logic                  queue_full,
    output logic                  push,
    output bpss_pkg::cmd_t        cmd
);
    import bpss_pkg::*;

    logic [3:0]        hdr_cnt_reg, hdr_cnt_next, hdr_cnt_inc;
    logic [PAIR_W-1:0] shift_reg, shift_next, shift_fill;
    logic [31:0]       start_reg, start_next, start_fill;
    logic [31:0]       skip_reg, skip_next;
    logic [31:0]       prev_end_reg, prev_end_next;
    logic              in_data_reg, in_data_next;
    logic              broken_reg, broken_next;
    logic [31:0]       end_w, len_w;
    logic              accept, take, finishing, hunk_done;
    logic [DELTA_W-1:0] hunk_part, tail_part;

    assign patch_ready = !queue_full;
    assign accept      = patch_valid && patch_ready;
    assign take        = accept && byte_valid && !broken_reg;
    assign finishing   = accept && last_item;

    assign hdr_cnt_inc = hdr_cnt_reg + 4'd1;
    assign shift_fill  = {shift_reg[PAIR_W-9:0], patch_byte};
    assign start_fill  = {start_reg[23:0], patch_byte};
    assign end_w       = shift_fill[PAIR_W-1:32];
    assign len_w       = shift_fill[31:0];

    always_comb
    begin
        hdr_cnt_next  = hdr_cnt_reg;
        shift_next    = shift_reg;
        start_next    = start_reg;
        skip_next     = skip_reg;
        prev_end_next = prev_end_reg;
        in_data_next  = in_data_reg;
        broken_next   = broken_reg;
        hunk_done     = 1'b0;
        hunk_part     = '0;
        tail_part     = '0;
        cmd           = '0;

        if (take)
        begin
            if (in_data_reg)
            begin
                // skip one data byte
                skip_next = skip_reg - 32'd1;
                if (skip_reg == 32'd1)
                begin
                    in_data_next = 1'b0;
                end
            end
            else
            begin
                if (hdr_cnt_reg < WORD_BYTES)
                begin
                    start_next = start_fill;
                end
                else
                begin
                    shift_next = shift_fill;
                end
                hdr_cnt_next = hdr_cnt_inc;
                if (hdr_cnt_inc == HEADER_BYTES)
                begin
                    hdr_cnt_next = '0;
                    shift_next   = '0;
                    if (start_reg > end_w)
                    begin
                        broken_next = 1'b1;
                    end
                    else
                    begin
                        hunk_done     = 1'b1;
                        hunk_part     = {3'b000, start_reg} - {3'b000, prev_end_reg}
                                        + {3'b000, len_w};
                        prev_end_next = end_w;
                        start_next    = '0;
                        skip_next     = len_w;
                        in_data_next  = (len_w != 32'd0);
                    end
                end
            end
        end

        if (finishing)
        begin
            tail_part  = {3'b000, orig_length} - {3'b000, prev_end_next};
            cmd.finish = 1'b1;
            cmd.bad    = broken_next || (hdr_cnt_next != 4'd0) || in_data_next;
            // drop all stream state for the next delta
            hdr_cnt_next  = '0;
            shift_next    = '0;
            start_next    = '0;
            skip_next     = '0;
            prev_end_next = '0;
            in_data_next  = 1'b0;
            broken_next   = 1'b0;
        end

        cmd.delta = hunk_part + tail_part;
    end

    assign push = hunk_done || finishing;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_cnt_reg  <= '0;
            shift_reg    <= '0;
            start_reg    <= '0;
            skip_reg     <= '0;
            prev_end_reg <= '0;
            in_data_reg  <= 1'b0;
            broken_reg   <= 1'b0;
        end
        else
        begin
            hdr_cnt_reg  <= hdr_cnt_next;
            shift_reg    <= shift_next;
            start_reg    <= start_next;
            skip_reg     <= skip_next;
            prev_end_reg <= prev_end_next;
            in_data_reg  <= in_data_next;
            broken_reg   <= broken_next;
        end
    end

    a_hdr_excludes_data: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_cnt_reg != 4'd0) |-> !in_data_reg)
        else $error("header collection overlaps data skip");

    a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        in_data_reg |-> (skip_reg != 32'd0))
        else $error("data skip active with nothing left to skip");

endmodule

// ----- rtl/core/bpss_queue.sv -----
// ----------------------------------------------------------------------------
// bpss_queue
// Small command queue between front and back end.
// ----------------------------------------------------------------------------
module bpss_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bpss_pkg::cmd_t push_data,
    input  logic           pop,
    output bpss_pkg::cmd_t head,
    output logic           not_empty,
    output logic           full
);
    import bpss_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entries [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head      = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("request pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from an empty queue");

endmodule

// ----- rtl/core/bpss_back.sv -----
// ----------------------------------------------------------------------------
// bpss_back
// Accumulates the running size from queued commands and holds the result.
// ----------------------------------------------------------------------------
module bpss_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bpss_pkg::cmd_t               head,
    input  logic                         not_empty,
    output logic                         pop,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [bpss_pkg::SIZE_W-1:0]  patched_size,
    output logic                         status
);
    import bpss_pkg::*;

    logic [SIZE_W-1:0] running_reg, running_next;
    logic [SIZE_W-1:0] sum;
    logic              out_valid_reg, out_valid_next;
    logic [SIZE_W-1:0] size_reg;
    logic              status_reg;
    logic              slot_free;

    assign sum       = running_reg + {{(SIZE_W-DELTA_W){head.delta[DELTA_W-1]}}, head.delta};
    assign slot_free = !out_valid_reg || result_ready;
    assign pop       = not_empty && (!head.finish || slot_free);

    always_comb
    begin
        running_next   = running_reg;
        out_valid_next = out_valid_reg;
        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop)
        begin
            if (head.finish)
            begin
                running_next   = '0;
                out_valid_next = 1'b1;
            end
            else
            begin
                running_next = sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.finish)
        begin
            size_reg   <= head.bad ? '0 : sum;
            status_reg <= head.bad;
        end
    end

    assign result_valid = out_valid_reg;
    assign patched_size = size_reg;
    assign status       = status_reg;

    a_error_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status) |-> (patched_size == '0))
        else $error("error result carries a nonzero size");

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the binary patch size scanner against a predictor of its own.
// Delta streams of hunk headers and data bytes are sent one byte per request,
// with random bursts and gaps on the request side and stalls on the result
// side. Each result request is compared, field by field, with the size and
// status that the predictor worked out for the stream that it closes.
// ----------------------------------------------------------------------------
module testbench;

    import bpss_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned DRAIN_CYCLES = 8;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    // One request on the patch channel
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       ends;
    } delta_item_t;

    // One result request as the predictor expects it
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              status;
    } size_result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [31:0]       cfg_wr_data;
    logic              patch_valid;
    logic              patch_ready;
    logic [7:0]        patch_byte;
    logic              byte_valid;
    logic              last_item;
    logic              result_valid;
    logic              result_ready;
    logic [SIZE_W-1:0] patched_size;
    logic              status;

    binary_patch_size_scanner DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .patch_valid  (patch_valid),
        .patch_ready  (patch_ready),
        .patch_byte   (patch_byte),
        .byte_valid   (byte_valid),
        .last_item    (last_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .patched_size (patched_size),
        .status       (status)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the scanner's register and of
    // everything it keeps while walking one delta stream.
    // ------------------------------------------------------------------
    logic [31:0]       orig_len_model;
    logic [3:0]        hdr_cnt;
    logic              skipping;
    logic [PAIR_W-1:0] end_len_shift;
    logic [31:0]       start_word;
    logic [31:0]       bytes_to_skip;
    logic [31:0]       last_end;
    logic [SIZE_W-1:0] size_acc;
    logic              corrupt;

    // Sizes still owed by the block, oldest first
    size_result_t pending_sizes[$];

    // Stream under construction before it is sent
    delta_item_t delta_q[$];

    int unsigned mismatch_count;
    int unsigned results_checked;
    int unsigned error_results;
    int unsigned streams_sent;
    int unsigned bytes_sent;
    int unsigned live_items;
    int unsigned orig_writes;
    int unsigned cycle_count;
    int unsigned burst_left;
    int unsigned drain_cycle;
    int unsigned hold_left;
    bit          scatter_holes;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void clear_scan();
        hdr_cnt       = '0;
        skipping      = 1'b0;
        end_len_shift = '0;
        start_word    = '0;
        bytes_to_skip = '0;
        last_end      = '0;
        size_acc      = '0;
        corrupt       = 1'b0;
    endfunction

    // Walk one delta byte: skip hunk data, or collect header bytes and
    // fold a finished header into the running size.
    function automatic void scan_byte(input logic [7:0] b);
        logic [31:0] end_w;
        logic [31:0] len_w;
        if (corrupt)
            return;
        if (skipping)
        begin
            bytes_to_skip = bytes_to_skip - 32'd1;
            if (bytes_to_skip == 0)
                skipping = 1'b0;
            return;
        end
        if (hdr_cnt < WORD_BYTES)
            start_word = {start_word[23:0], b};
        else
            end_len_shift = {end_len_shift[PAIR_W-9:0], b};
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= HEADER_BYTES)
        begin
            end_w         = end_len_shift[PAIR_W-1:32];
            len_w         = end_len_shift[31:0];
            hdr_cnt       = '0;
            end_len_shift = '0;
            // start above end: drop everything up to the end of the stream
            if (start_word > end_w)
            begin
                corrupt = 1'b1;
                return;
            end
            size_acc      = size_acc + {32'd0, start_word} - {32'd0, last_end}
                            + {32'd0, len_w};
            last_end      = end_w;
            start_word    = '0;
            bytes_to_skip = len_w;
            skipping      = (len_w != 0);
        end
    endfunction

    // Apply one accepted request; on the closing request queue the result.
    function automatic void scan_request(input delta_item_t it);
        size_result_t want;
        if (it.has_byte)
            scan_byte(it.data);
        if (it.ends)
        begin
            // a broken header, a cut header or cut hunk data all fail
            if (corrupt || hdr_cnt != 0 || skipping)
            begin
                want.size   = '0;
                want.status = STATUS_BAD;
                error_results++;
            end
            else
            begin
                want.size   = size_acc + {32'd0, orig_len_model} - {32'd0, last_end};
                want.status = STATUS_OK;
            end
            pending_sizes.push_back(want);
            clear_scan();
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side: bursts of random length with random gaps in between.
    // Hold valid and payload until the request is taken, then advance the
    // predictor with it.
    // ------------------------------------------------------------------
    task automatic send_request(input delta_item_t it);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                patch_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        patch_valid <= 1'b1;
        patch_byte  <= it.data;
        byte_valid  <= it.has_byte;
        last_item   <= it.ends;
        do
            @(posedge clk);
        while (!patch_ready);
        // count only requests that the block does not just ignore
        if ((it.has_byte && !corrupt) || it.ends)
            live_items++;
        if (it.has_byte)
            bytes_sent++;
        scan_request(it);
    endtask

    // Write orig_length once the block has drained and gone quiet.
    task automatic set_orig_length(input logic [31:0] value);
        patch_valid <= 1'b0;
        while (pending_sizes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        orig_len_model  = value;
        orig_writes++;
    endtask

    // ------------------------------------------------------------------
    // Stream building: collect requests in delta_q, then play them out.
    // ------------------------------------------------------------------
    function automatic void add_hole();
        delta_item_t it;
        it.data     = 8'($urandom);
        it.has_byte = 1'b0;
        it.ends     = 1'b0;
        delta_q.push_back(it);
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        delta_item_t it;
        // sprinkle empty requests mid-stream during the random part
        if (scatter_holes && $urandom_range(0, 19) == 0)
            add_hole();
        it.data     = b;
        it.has_byte = 1'b1;
        it.ends     = 1'b0;
        delta_q.push_back(it);
    endfunction

    function automatic void add_word(input logic [31:0] w);
        add_byte(w[31:24]);
        add_byte(w[23:16]);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
    endfunction

    function automatic void add_header(input logic [31:0] s, input logic [31:0] e,
                                       input logic [31:0] n);
        add_word(s);
        add_word(e);
        add_word(n);
    endfunction

    function automatic void add_data(input int unsigned n);
        repeat (n) add_byte(8'($urandom));
    endfunction

    // Close the stream either with an empty request or on its last byte.
    task automatic play_stream(input bit close_empty);
        delta_item_t it;
        if (close_empty || delta_q.size() == 0)
        begin
            it.data     = 8'($urandom);
            it.has_byte = 1'b0;
            it.ends     = 1'b1;
            delta_q.push_back(it);
        end
        else
            delta_q[delta_q.size()-1].ends = 1'b1;
        foreach (delta_q[i])
            send_request(delta_q[i]);
        delta_q.delete();
        streams_sent++;
    endtask

    // A well-formed hunk: start no greater than end, a few data bytes.
    function automatic void add_good_hunk();
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] n;
        case ($urandom_range(0, 3))
            0:
            begin
                a = $urandom_range(0, 400);
                b = a + $urandom_range(0, 60);
            end
            1:
            begin
                a = 32'd0;
                b = 32'hFFFF_FFFF;
            end
            default:
            begin
                a = $urandom;
                b = $urandom;
            end
        endcase
        if (a > b)
        begin
            n = a;
            a = b;
            b = n;
        end
        n = ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom_range(1, 5);
        add_header(a, b, n);
        add_data(n);
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    task automatic test_empty_delta();
        // orig_length is still at its reset value of zero
        play_stream(1'b1);
    endtask

    task automatic test_clean_hunk();
        set_orig_length(32'd1000);
        add_header(32'h0000_0010, 32'h0000_0020, 32'd2);
        add_hole();
        add_data(2);
        play_stream(1'b0);
    endtask

    task automatic test_start_above_end();
        // the header ends the stream on its own last byte
        add_header(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        play_stream(1'b0);
    endtask

    task automatic test_truncated_header();
        add_byte(8'hFF);
        add_hole();
        add_byte(8'h00);
        add_byte(8'hA5);
        play_stream(1'b0);
    endtask

    task automatic test_truncated_data();
        add_header(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        add_byte(8'h5A);
        play_stream(1'b0);
    endtask

    task automatic test_orig_length_extremes();
        set_orig_length(32'hFFFF_FFFF);
        play_stream(1'b1);
        add_header(32'h0000_0000, 32'h8000_0000, 32'd1);
        add_byte(8'hFF);
        play_stream(1'b1);
        set_orig_length(32'h0000_0000);
        add_header(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        play_stream(1'b0);
    endtask

    // ------------------------------------------------------------------
    // Random streams: mostly well-formed, the rest broken or noise.
    // ------------------------------------------------------------------
    task automatic test_random_streams();
        int unsigned goal;
        int unsigned kind;
        int unsigned cut;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] n;
        goal          = live_items + RANDOM_ITEMS;
        scatter_holes = 1'b1;
        while (live_items < goal)
        begin
            if (streams_sent % 25 == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       set_orig_length(32'h0000_0000);
                    1:       set_orig_length(32'hFFFF_FFFF);
                    2:       set_orig_length($urandom_range(0, 4096));
                    default: set_orig_length($urandom);
                endcase
            end
            kind = $urandom_range(0, 99);
            if (kind < 94)
                repeat ($urandom_range(0, 3)) add_good_hunk();
            if (kind < 70)
                add_good_hunk();
            else if (kind < 78)
            begin
                // start above end, then some bytes that must be dropped
                a = $urandom | 32'h1;
                b = $urandom_range(0, 1) ? $urandom % a : a - 1;
                add_header(a, b, $urandom);
                add_data($urandom_range(0, 14));
            end
            else if (kind < 86)
                add_data($urandom_range(1, 11));
            else if (kind < 94)
            begin
                n = $urandom_range(0, 1) ? ($urandom | 32'h1) : $urandom_range(1, 6);
                add_header($urandom_range(0, 100), $urandom_range(100, 200), n);
                cut = (n > 5) ? 5 : n - 1;
                add_data($urandom_range(0, cut));
            end
            else if (kind >= 97)
                add_data($urandom_range(1, 30));
            play_stream($urandom_range(0, 1));
        end
        patch_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: stall on a pattern that moves through free-running,
    // light and heavy phases.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        drain_cycle++;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
            case ((drain_cycle / 300) % 3)
                1:
                    if ($urandom_range(0, 2) == 0)
                        hold_left = $urandom_range(1, 3);
                2:
                    if ($urandom_range(0, 1) == 0)
                        hold_left = $urandom_range(2, 10);
                default:
                    hold_left = 0;
            endcase
        end
    end

    // Compare every accepted result request with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_sizes.size() == 0)
                report_mismatch($sformatf("unexpected result size=%h status=%b",
                                          patched_size, status));
            else
            begin
                if (patched_size !== pending_sizes[0].size)
                    report_mismatch($sformatf("patched_size %h, want %h",
                                              patched_size, pending_sizes[0].size));
                if (status !== pending_sizes[0].status)
                    report_mismatch($sformatf("status %b, want %b",
                                              status, pending_sizes[0].status));
                void'(pending_sizes.pop_front());
                results_checked++;
            end
        end
    end

    // Stop a hung run.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[binary_patch_size_scanner] ERROR");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        patch_valid   = 1'b0;
        patch_byte    = '0;
        byte_valid    = 1'b0;
        last_item     = 1'b0;
        scatter_holes = 1'b0;
        orig_len_model = '0;
        clear_scan();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_delta();
        test_clean_hunk();
        test_start_above_end();
        test_truncated_header();
        test_truncated_data();
        test_orig_length_extremes();
        test_random_streams();

        // drain what is still owed, then give stray results time to show
        while (pending_sizes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d delta streams, %0d delta bytes, %0d error results.",
                 streams_sent, bytes_sent, error_results);
        $display("Checked %0d results over %0d orig_length settings, %0d mismatches.",
                 results_checked, orig_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("[binary_patch_size_scanner] OK");
        else
            $display("[binary_patch_size_scanner] ERROR");
        $finish;
    end

endmodule
